>>> rtl/imte_pkg.sv
// ----------------------------------------------------------------------------
// imte_pkg
// shared types and constants of the i2c master transaction engine
// ----------------------------------------------------------------------------
`default_nettype none

package imte_pkg;

	localparam int unsigned HP_W = 16;
	localparam logic [HP_W-1:0] HALF_PERIOD_RST = 16'd10;
	localparam logic [3:0] RESET_PULSES = 4'd10;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_RESET = 2'd3
	} cmd_t;

	typedef enum logic [15:0] {
		PH_IDLE = 16'h0001,
		PH_ST0  = 16'h0002,
		PH_ST1  = 16'h0004,
		PH_ST2  = 16'h0008,
		PH_WHI  = 16'h0010,
		PH_WLO  = 16'h0020,
		PH_AHI  = 16'h0040,
		PH_ALO  = 16'h0080,
		PH_RHI  = 16'h0100,
		PH_RLO  = 16'h0200,
		PH_MHI  = 16'h0400,
		PH_MLO  = 16'h0800,
		PH_P0   = 16'h1000,
		PH_P1   = 16'h2000,
		PH_BLO  = 16'h4000,
		PH_BHI  = 16'h8000
	} phase_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [6:0] addr;
		logic [7:0] length;
		logic [7:0] tx_byte;
		logic       sda_in;
		logic       scl_in;
	} req_t;

	typedef struct packed {
		logic       scl_low;
		logic       sda_low;
		logic       busy_res;
		logic       tx_taken;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       done_res;
		logic       acked;
		logic       slave_busy;
	} rsp_t;

endpackage

`default_nettype wire

>>> rtl/imte_ifs.sv
// ----------------------------------------------------------------------------
// imte interfaces
// valid/ready channels for ticks, results and the half period register
// ----------------------------------------------------------------------------
`default_nettype none

interface imte_req_if import imte_pkg::*;;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport mon (input valid, input data, input ready);
endinterface

interface imte_rsp_if import imte_pkg::*;;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport mon (input valid, input data, input ready);
endinterface

interface imte_cfg_if import imte_pkg::*;;
	logic            valid;
	logic            ready;
	logic [HP_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport mon (input valid, input data, input ready);
endinterface

`default_nettype wire

>>> rtl/i2c_master_transaction_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_transaction_engine
// tick-driven i2c master: start, address, write or read bytes, stop, bus reset
// ----------------------------------------------------------------------------
// the result of a tick is registered and presented in the cycle after its transfer
// throughput: one tick per cycle while results are taken, set by the single result register
// a held result does not block the next tick while the result is taken
// reset: asynchronous, engine idle, lines released, half period 10
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transaction_engine import imte_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	imte_req_if.sink   req,
	imte_rsp_if.source rsp,
	imte_cfg_if.sink   cfg
);

	logic [HP_W-1:0] half_period_q;
	logic            step;
	logic            rsp_valid_q;
	rsp_t            rsp_data_q;
	rsp_t            result;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign step      = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	imte_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (req.data),
		.half_period (half_period_q),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RST;
		end else if (cfg.valid && cfg.ready) begin
			half_period_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_data_q <= result;
		end
	end

endmodule

`default_nettype wire

>>> rtl/imte_seq.sv
// ----------------------------------------------------------------------------
// imte_seq
// bus phase sequencer: state registers and next-state logic for one tick
// ----------------------------------------------------------------------------
`default_nettype none

module imte_seq import imte_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire req_t            item,
	input  wire logic [HP_W-1:0] half_period,
	output rsp_t                 result
);

	phase_t          phase_q, phase_n;
	logic [HP_W-1:0] timer_q, timer_n, timer_dec, hp_eff;
	logic [3:0]      bit_q, bit_n, bit_inc;
	logic [7:0]      bytes_q, bytes_n;
	logic [7:0]      shift_q, shift_n;
	logic            read_q, read_n;
	logic            ack_q, ack_n;
	logic [3:0]      pulse_q, pulse_n, pulse_inc;
	logic            scl_q, scl_n;
	logic            sda_q, sda_n;
	logic            txt, rxv, done;

	assign hp_eff    = (half_period == '0) ? {{(HP_W-1){1'b0}}, 1'b1} : half_period;
	assign timer_dec = timer_q - {{(HP_W-1){1'b0}}, 1'b1};
	assign bit_inc   = bit_q + 4'd1;
	assign pulse_inc = pulse_q + 4'd1;

	always_comb begin
		phase_n = phase_q;
		timer_n = timer_q;
		bit_n   = bit_q;
		bytes_n = bytes_q;
		shift_n = shift_q;
		read_n  = read_q;
		ack_n   = ack_q;
		pulse_n = pulse_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		txt     = 1'b0;
		rxv     = 1'b0;
		done    = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (item.cmd == CMD_WRITE || item.cmd == CMD_READ) begin
				read_n  = (item.cmd == CMD_READ);
				shift_n = {item.addr, item.cmd == CMD_READ};
				bytes_n = item.length;
				bit_n   = 4'd0;
				phase_n = PH_ST0;
				scl_n   = 1'b0;
				sda_n   = 1'b0;
				timer_n = hp_eff;
			end else if (item.cmd == CMD_RESET) begin
				pulse_n = 4'd0;
				phase_n = PH_BLO;
				scl_n   = 1'b1;
				sda_n   = 1'b0;
				timer_n = hp_eff;
			end
		end else begin
			timer_n = timer_dec;
			if (timer_dec == '0) begin
				timer_n = hp_eff;
				case (phase_q)
					PH_ST0: begin
						phase_n = PH_ST1; scl_n = 1'b0; sda_n = 1'b1;
					end
					PH_ST1: begin
						phase_n = PH_ST2; scl_n = 1'b1; sda_n = 1'b1;
					end
					PH_ST2: begin
						phase_n = PH_WHI; scl_n = 1'b0; sda_n = !shift_q[7];
					end
					PH_WHI: begin
						phase_n = PH_WLO; scl_n = 1'b1; sda_n = sda_q;
					end
					PH_WLO: begin
						shift_n = {shift_q[6:0], 1'b0};
						bit_n   = bit_inc;
						scl_n   = 1'b0;
						if (bit_inc >= BITS_PER_BYTE) begin
							phase_n = PH_AHI; sda_n = 1'b0;
						end else begin
							phase_n = PH_WHI; sda_n = !shift_q[6];
						end
					end
					PH_AHI: begin
						ack_n   = !item.sda_in;
						phase_n = PH_ALO; scl_n = 1'b1; sda_n = 1'b0;
					end
					PH_ALO: begin
						scl_n = 1'b0;
						if (ack_q && bytes_q != 8'd0) begin
							bytes_n = bytes_q - 8'd1;
							bit_n   = 4'd0;
							if (read_q) begin
								shift_n = 8'd0;
								phase_n = PH_RHI; sda_n = 1'b0;
							end else begin
								shift_n = item.tx_byte;
								txt     = 1'b1;
								phase_n = PH_WHI; sda_n = !item.tx_byte[7];
							end
						end else begin
							phase_n = PH_P0; sda_n = 1'b1;
						end
					end
					PH_RHI: begin
						shift_n = {shift_q[6:0], item.sda_in};
						phase_n = PH_RLO; scl_n = 1'b1; sda_n = 1'b0;
					end
					PH_RLO: begin
						bit_n = bit_inc;
						scl_n = 1'b0;
						if (bit_inc >= BITS_PER_BYTE) begin
							phase_n = PH_MHI; sda_n = (bytes_q != 8'd0);
						end else begin
							phase_n = PH_RHI; sda_n = 1'b0;
						end
					end
					PH_MHI: begin
						phase_n = PH_MLO; scl_n = 1'b1; sda_n = sda_q;
					end
					PH_MLO: begin
						rxv   = 1'b1;
						scl_n = 1'b0;
						if (bytes_q != 8'd0) begin
							bytes_n = bytes_q - 8'd1;
							bit_n   = 4'd0;
							shift_n = 8'd0;
							phase_n = PH_RHI; sda_n = 1'b0;
						end else begin
							phase_n = PH_P0; sda_n = 1'b1;
						end
					end
					PH_P0: begin
						phase_n = PH_P1; scl_n = 1'b0; sda_n = 1'b0;
					end
					PH_P1: begin
						done    = 1'b1;
						phase_n = PH_IDLE; scl_n = 1'b0; sda_n = 1'b0;
						timer_n = '0;
					end
					PH_BLO: begin
						phase_n = PH_BHI; scl_n = 1'b0; sda_n = 1'b0;
					end
					PH_BHI: begin
						pulse_n = pulse_inc;
						if (pulse_inc >= RESET_PULSES) begin
							phase_n = PH_IDLE; scl_n = 1'b0; sda_n = 1'b0;
							timer_n = '0;
						end else begin
							phase_n = PH_BLO; scl_n = 1'b1; sda_n = 1'b0;
						end
					end
					default: begin
						phase_n = PH_IDLE; scl_n = 1'b0; sda_n = 1'b0;
						timer_n = '0;
					end
				endcase
			end
		end
	end

	always_comb begin
		result.scl_low    = scl_n;
		result.sda_low    = sda_n;
		result.busy_res   = (phase_n != PH_IDLE);
		result.tx_taken   = txt;
		result.rx_byte    = rxv ? shift_q : 8'd0;
		result.rx_valid   = rxv;
		result.done_res   = done;
		result.acked      = ack_n;
		result.slave_busy = !item.scl_in && !scl_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			bit_q   <= 4'd0;
			bytes_q <= 8'd0;
			shift_q <= 8'd0;
			read_q  <= 1'b0;
			ack_q   <= 1'b0;
			pulse_q <= 4'd0;
			scl_q   <= 1'b0;
			sda_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			timer_q <= timer_n;
			bit_q   <= bit_n;
			bytes_q <= bytes_n;
			shift_q <= shift_n;
			read_q  <= read_n;
			ack_q   <= ack_n;
			pulse_q <= pulse_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
		end
	end

endmodule

`default_nettype wire

>>> rtl/imte_chk.sv
// ----------------------------------------------------------------------------
// imte_chk
// port-level checks of the i2c master transaction engine
// ----------------------------------------------------------------------------
`default_nettype none

module imte_chk import imte_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp_data
);

	// a result waiting to be taken stays
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result dropped or changed while stalled");

	// every transferred tick yields a result next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("tick transfer without result");

	// stop completion leaves the engine idle with lines released
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.done_res |->
		!rsp_data.busy_res && !rsp_data.scl_low && !rsp_data.sda_low)
		else $error("done while busy or driving");

	// received byte is zero unless flagged
	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.rx_valid |-> rsp_data.rx_byte == 8'd0)
		else $error("rx byte without rx valid");

	// a new write byte is taken only mid transfer with scl released
	a_tx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.tx_taken |->
		rsp_data.busy_res && !rsp_data.scl_low && !rsp_data.rx_valid)
		else $error("tx byte taken outside a write");

endmodule

bind i2c_master_transaction_engine imte_chk u_imte_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire

>>> sim/tb_i2c_master_transaction_engine.sv
// ----------------------------------------------------------------------------
// tb_i2c_master_transaction_engine
// Sends bus ticks that carry commands and sampled line levels. The
// testbench keeps its own model of the engine, with the phase sequence,
// the timer, the shift register and the acknowledge flag, and checks every
// result field against it. It covers writes, reads, bus resets, commands
// sent while busy, half period extremes and output back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_i2c_master_transaction_engine;
	timeunit 1ns;
	timeprecision 1ps;
	import imte_pkg::*;

	logic clk;
	logic arst_n;

	imte_req_if req_ch ();
	imte_rsp_if rsp_ch ();
	imte_cfg_if cfg_ch ();

	i2c_master_transaction_engine uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// predicted engine state
	logic [HP_W-1:0] m_half;
	phase_t          m_phase;
	logic [15:0]     m_timer;
	logic [3:0]      m_bits;
	logic [3:0]      m_pulses;
	logic [7:0]      m_left;
	logic [7:0]      m_shift;
	logic            m_rd;
	logic            m_ack;
	logic            m_scl;
	logic            m_sda;

	rsp_t       expected_lines_q[$];
	logic [7:0] host_tx;
	int         err_count = 0;
	int         ticks_sent = 0;
	int         results_seen = 0;
	int         send_idle_pct = 28;
	int         rsp_idle_pct = 28;
	int         rsp_stall_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("i2c_master_transaction_engine: mismatch");
		$finish;
	end

	function automatic void reset_engine_model();
		m_half = HALF_PERIOD_RST;
		m_phase = PH_IDLE;
		m_timer = '0;
		m_bits = '0;
		m_pulses = '0;
		m_left = '0;
		m_shift = '0;
		m_rd = 1'b0;
		m_ack = 1'b0;
		m_scl = 1'b0;
		m_sda = 1'b0;
	endfunction

	function automatic void enter_phase(phase_t ph, logic scl, logic sda);
		m_phase = ph;
		m_scl = scl;
		m_sda = sda;
		m_timer = (m_half != '0) ? m_half : 16'd1;
	endfunction

	function automatic void go_idle();
		m_phase = PH_IDLE;
		m_scl = 1'b0;
		m_sda = 1'b0;
		m_timer = '0;
	endfunction

	function automatic void start_read_byte();
		m_left = m_left - 8'd1;
		m_bits = '0;
		m_shift = '0;
		enter_phase(PH_RHI, 1'b0, 1'b0);
	endfunction

	function automatic void predict_bus_tick(input req_t r, output rsp_t o);
		logic       txt;
		logic       rxv;
		logic       done;
		logic [7:0] rx;
		logic       sbusy;
		txt = 1'b0;
		rxv = 1'b0;
		done = 1'b0;
		rx = '0;
		sbusy = !r.scl_in && !m_scl;
		if (m_phase == PH_IDLE) begin
			if (r.cmd == CMD_WRITE || r.cmd == CMD_READ) begin
				m_rd = (r.cmd == CMD_READ);
				m_shift = {r.addr, m_rd};
				m_left = r.length;
				m_bits = '0;
				enter_phase(PH_ST0, 1'b0, 1'b0);
			end else if (r.cmd == CMD_RESET) begin
				m_pulses = '0;
				enter_phase(PH_BLO, 1'b1, 1'b0);
			end
		end else begin
			m_timer = m_timer - 16'd1;
			if (m_timer == '0) begin
				case (m_phase)
					PH_ST0: enter_phase(PH_ST1, 1'b0, 1'b1);
					PH_ST1: enter_phase(PH_ST2, 1'b1, 1'b1);
					PH_ST2: enter_phase(PH_WHI, 1'b0, !m_shift[7]);
					PH_WHI: enter_phase(PH_WLO, 1'b1, m_sda);
					PH_WLO: begin
						m_shift = m_shift << 1;
						m_bits = m_bits + 4'd1;
						if (m_bits >= BITS_PER_BYTE)
							enter_phase(PH_AHI, 1'b0, 1'b0);
						else
							enter_phase(PH_WHI, 1'b0, !m_shift[7]);
					end
					PH_AHI: begin
						m_ack = !r.sda_in;
						enter_phase(PH_ALO, 1'b1, 1'b0);
					end
					PH_ALO: begin
						if (m_ack && m_left != '0) begin
							if (m_rd) begin
								start_read_byte();
							end else begin
								txt = 1'b1;
								m_left = m_left - 8'd1;
								m_bits = '0;
								m_shift = r.tx_byte;
								enter_phase(PH_WHI, 1'b0, !r.tx_byte[7]);
							end
						end else begin
							enter_phase(PH_P0, 1'b0, 1'b1);
						end
					end
					PH_RHI: begin
						m_shift = {m_shift[6:0], r.sda_in};
						enter_phase(PH_RLO, 1'b1, 1'b0);
					end
					PH_RLO: begin
						m_bits = m_bits + 4'd1;
						if (m_bits >= BITS_PER_BYTE)
							enter_phase(PH_MHI, 1'b0, m_left != '0);
						else
							enter_phase(PH_RHI, 1'b0, 1'b0);
					end
					PH_MHI: enter_phase(PH_MLO, 1'b1, m_sda);
					PH_MLO: begin
						rxv = 1'b1;
						rx = m_shift;
						if (m_left != '0)
							start_read_byte();
						else
							enter_phase(PH_P0, 1'b0, 1'b1);
					end
					PH_P0: enter_phase(PH_P1, 1'b0, 1'b0);
					PH_P1: begin
						done = 1'b1;
						go_idle();
					end
					PH_BLO: enter_phase(PH_BHI, 1'b0, 1'b0);
					PH_BHI: begin
						m_pulses = m_pulses + 4'd1;
						if (m_pulses >= RESET_PULSES)
							go_idle();
						else
							enter_phase(PH_BLO, 1'b1, 1'b0);
					end
					default: go_idle();
				endcase
			end
		end
		o.scl_low = m_scl;
		o.sda_low = m_sda;
		o.busy_res = (m_phase != PH_IDLE);
		o.tx_taken = txt;
		o.rx_byte = rxv ? rx : 8'd0;
		o.rx_valid = rxv;
		o.done_res = done;
		o.acked = m_ack;
		o.slave_busy = sbusy;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		err_count++;
		if (err_count <= 100)
			$display("result %0d %s: got %0h, want %0h", results_seen, what, got, want);
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch(name, 16'(got), 16'(want));
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			if (expected_lines_q.size() == 0) begin
				report_mismatch("result with nothing expected", '0, '0);
			end else begin
				want = expected_lines_q.pop_front();
				check_field("scl_low", 8'(rsp_ch.data.scl_low), 8'(want.scl_low));
				check_field("sda_low", 8'(rsp_ch.data.sda_low), 8'(want.sda_low));
				check_field("busy_res", 8'(rsp_ch.data.busy_res), 8'(want.busy_res));
				check_field("tx_taken", 8'(rsp_ch.data.tx_taken), 8'(want.tx_taken));
				check_field("rx_byte", rsp_ch.data.rx_byte, want.rx_byte);
				check_field("rx_valid", 8'(rsp_ch.data.rx_valid), 8'(want.rx_valid));
				check_field("done_res", 8'(rsp_ch.data.done_res), 8'(want.done_res));
				check_field("acked", 8'(rsp_ch.data.acked), 8'(want.acked));
				check_field("slave_busy", 8'(rsp_ch.data.slave_busy),
					8'(want.slave_busy));
			end
		end
	end

	// result receiver, with an optional long hold-off
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_stall_cycles != 0) begin
				rsp_ch.ready <= 1'b0;
				for (int k = 0; k < rsp_stall_cycles; k++)
					@(posedge clk);
				rsp_stall_cycles = 0;
			end
			rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	task automatic send_tick(input req_t r);
		rsp_t want;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct * 5 / 7) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
		predict_bus_tick(r, want);
		expected_lines_q.push_back(want);
		ticks_sent++;
		// host offers a fresh byte once the last one was taken
		if (want.tx_taken)
			host_tx = 8'($urandom);
	endtask

	task automatic drain_results();
		int waited;
		waited = 0;
		req_ch.valid <= 1'b0;
		while (expected_lines_q.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (expected_lines_q.size() != 0) begin
			report_mismatch("results never produced", 16'(expected_lines_q.size()), '0);
			expected_lines_q.delete();
		end
	endtask

	task automatic set_half_period(input logic [HP_W-1:0] v);
		drain_results();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		m_half = v;
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic req_t bus_tick(input int ack_pct);
		req_t r;
		r.cmd = CMD_NONE;
		r.addr = 7'($urandom);
		r.length = 8'($urandom);
		r.tx_byte = host_tx;
		r.sda_in = 1'($urandom);
		if (m_phase == PH_AHI)
			r.sda_in = ($urandom_range(99) >= ack_pct);
		r.scl_in = ($urandom_range(99) >= 10);
		return r;
	endfunction

	task automatic run_bus_op(input cmd_t c, input logic [6:0] a, input logic [7:0] len,
			input int ack_pct, input int noise_pct);
		req_t r;
		r = bus_tick(ack_pct);
		r.cmd = c;
		r.addr = a;
		r.length = len;
		send_tick(r);
		while (m_phase != PH_IDLE) begin
			r = bus_tick(ack_pct);
			if ($urandom_range(99) < noise_pct)
				r.cmd = 2'($urandom_range(1, 3));
			send_tick(r);
		end
	endtask

	task automatic test_idle_ticks();
		req_t r;
		r = '{cmd: CMD_NONE, addr: 7'h7F, length: 8'hFF, tx_byte: 8'hFF,
			sda_in: 1'b1, scl_in: 1'b0};
		send_tick(r);
		r = '0;
		send_tick(r);
		r.scl_in = 1'b1;
		send_tick(r);
	endtask

	task automatic test_writes();
		run_bus_op(CMD_WRITE, 7'h7F, 8'd0, 100, 0);
		set_half_period(16'd1);
		run_bus_op(CMD_WRITE, 7'h00, 8'd255, 0, 0);
		run_bus_op(CMD_WRITE, 7'h2A, 8'd5, 100, 0);
		run_bus_op(CMD_WRITE, 7'h55, 8'd255, 70, 0);
	endtask

	task automatic test_reads();
		run_bus_op(CMD_READ, 7'h7F, 8'd0, 100, 0);
		run_bus_op(CMD_READ, 7'h01, 8'd5, 0, 0);
		run_bus_op(CMD_READ, 7'h33, 8'd4, 100, 0);
		run_bus_op(CMD_READ, 7'h4C, 8'd2, 100, 0);
	endtask

	task automatic test_bus_reset();
		set_half_period(16'd1);
		run_bus_op(CMD_RESET, 7'h00, 8'd0, 100, 0);
		run_bus_op(CMD_RESET, 7'h7F, 8'd255, 100, 50);
	endtask

	task automatic test_busy_commands();
		set_half_period(16'd1);
		run_bus_op(CMD_WRITE, 7'($urandom), 8'd3, 90, 60);
		run_bus_op(CMD_READ, 7'($urandom), 8'd3, 90, 60);
	endtask

	task automatic test_period_extremes();
		req_t r;
		set_half_period(16'd0);
		run_bus_op(CMD_WRITE, 7'h12, 8'd2, 100, 0);
		send_idle_pct = 0;
		rsp_idle_pct = 0;
		set_half_period(16'd120);
		r = bus_tick(100);
		r.cmd = CMD_RESET;
		send_tick(r);
		repeat (20) send_tick(bus_tick(100));
		// new period only applies from the next phase on
		set_half_period(16'd1);
		run_bus_op(CMD_NONE, 7'h00, 8'd0, 100, 0);
		send_idle_pct = 28;
		rsp_idle_pct = 28;
	endtask

	task automatic test_backpressure();
		set_half_period(16'd1);
		rsp_stall_cycles = 300;
		run_bus_op(CMD_WRITE, 7'($urandom), 8'd12, 100, 10);
	endtask

	task automatic test_random_ops();
		int         ops;
		int         k;
		int         ack_pct;
		int         noise_pct;
		cmd_t       c;
		logic [7:0] len;
		ops = 0;
		while (ticks_sent < 1800) begin
			if (ops % 4 == 0) begin
				k = $urandom_range(9);
				if (k == 0)
					set_half_period(16'd0);
				else if (k == 1)
					set_half_period(16'($urandom_range(2, 4)));
				else
					set_half_period(16'd1);
			end
			send_idle_pct = (ops >= 3 && ops < 6) ? 0 : 28;
			rsp_idle_pct = send_idle_pct;
			k = $urandom_range(99);
			c = (k < 38) ? CMD_WRITE : (k < 76) ? CMD_READ : (k < 86) ? CMD_RESET : CMD_NONE;
			k = $urandom_range(99);
			len = 8'((k < 80) ? $urandom_range(0, 2) :
				(k < 96) ? $urandom_range(3, 6) : $urandom_range(7, 16));
			k = $urandom_range(99);
			ack_pct = (k < 70) ? 92 : (k < 90) ? 50 : 5;
			noise_pct = ($urandom_range(99) < 15) ? 40 : 5;
			run_bus_op(c, 7'($urandom), len, ack_pct, noise_pct);
			ops++;
		end
		send_idle_pct = 28;
		rsp_idle_pct = 28;
	endtask

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		reset_engine_model();
		host_tx = 8'($urandom);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_ticks();
		test_writes();
		test_reads();
		test_bus_reset();
		test_busy_commands();
		test_period_extremes();
		test_backpressure();
		test_random_ops();

		drain_results();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("i2c_master_transaction_engine: match");
		else
			$display("i2c_master_transaction_engine: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
